// ===== rtl/imf_pkg.sv =====
// ----------------------------------------------------------------------------
// imf_pkg: shared constants and types
// Window geometry, pixel widths, register indexes and pipeline types of the
// streaming median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package imf_pkg;

    localparam int WINDOW      = 3;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int PIX_BITS    = 8;

    localparam int IO_PIX_BITS = 8;
    localparam int CFG_BITS    = 11;
    localparam int CFG_REGS    = 2;
    localparam int CFG_IDX_BITS = (CFG_REGS > 1) ? $clog2(CFG_REGS) : 1;

    localparam int WIN_AREA    = WINDOW * WINDOW;
    localparam int MED_IDX     = WIN_AREA / 2;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int DIM_BITS    = ((COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS) + 1;
    localparam int CMP_BITS    = (DIM_BITS > CFG_BITS) ? DIM_BITS : CFG_BITS;
    localparam int LINE_BITS   = (WINDOW - 1) * PIX_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [CFG_BITS-1:0] RESET_WIDTH  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] RESET_HEIGHT = CFG_BITS'(480);

    typedef logic [PIX_BITS-1:0] t_pix;
    typedef logic [WIN_AREA-1:0][PIX_BITS-1:0] t_win;

    typedef struct packed {
        logic full;
        logic last;
    } t_meta;

endpackage

`default_nettype wire

// ===== rtl/imf_pix_if.sv =====
// ----------------------------------------------------------------------------
// imf_pix_if: pixel input channel
// Valid/ready channel carrying one raster-order pixel per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface imf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/imf_res_if.sv =====
// ----------------------------------------------------------------------------
// imf_res_if: filtered pixel output channel
// Valid/ready channel carrying one median result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface imf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] median_pixel;
    logic       window_full;
    logic       frame_last;

    modport source (output valid, output median_pixel, output window_full,
                    output frame_last, input ready);
    modport sink   (input valid, input median_pixel, input window_full,
                    input frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/imf_ram.sv =====
// ----------------------------------------------------------------------------
// imf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/imf_sort_stage.sv =====
// ----------------------------------------------------------------------------
// imf_sort_stage: one cell of the odd-even transposition sorter
// Compare-exchange of neighboring window values on even or odd pairs,
// registered and handed to the next cell on every pipeline advance.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_sort_stage
    import imf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_adv,
    input  wire logic  i_odd,
    input  wire logic  i_valid,
    input  wire t_win  i_data,
    input  wire t_meta i_meta,
    output logic       o_valid,
    output t_win       o_data,
    output t_meta      o_meta
);

    t_win n_data;

    always_comb begin
        n_data = i_data;
        for (int i = 0; i < WIN_AREA - 1; i++) begin
            if ((1'(i) == i_odd) && (i_data[i] > i_data[i+1])) begin
                n_data[i]   = i_data[i+1];
                n_data[i+1] = i_data[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
        if (i_adv) begin
            o_data <= n_data;
            o_meta <= i_meta;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/image_median_filter.sv =====
// ----------------------------------------------------------------------------
// image_median_filter: streaming 3x3 median filter
// Line buffers feed a shifting window of pixel cells; a chain of
// compare-exchange cells sorts the window and the middle value is emitted.
// Path: the input register, the window register, then the chain of sort cells.
// Throughput: one pixel per cycle; the whole pipeline holds while a result
// waits at the output, and no pixel is taken then.
// Reset: position counters to zero, window to zero, width 640, height 480;
// the line store is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module image_median_filter
    import imf_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    imf_pix_if.sink                      i_pix,
    imf_res_if.source                    o_res,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data
);

    logic [CFG_BITS-1:0]  r_width;
    logic [CFG_BITS-1:0]  r_height;
    logic [COL_BITS-1:0]  r_col;
    logic [ROW_BITS-1:0]  r_row;

    logic                 r_s1_valid;
    t_pix                 r_s1_px;
    logic [COL_BITS-1:0]  r_s1_col;
    t_meta                r_s1_meta;
    logic                 r_fwd;
    logic [LINE_BITS-1:0] r_fwd_data;

    t_pix                 r_win [WINDOW][WINDOW];
    t_pix                 n_win [WINDOW][WINDOW];

    logic                 r_st0_valid;
    t_win                 r_st0_data;
    t_meta                r_st0_meta;
    t_win                 n_st0_data;

    logic                 w_adv;
    logic                 w_accept;
    logic [CMP_BITS-1:0]  w_width;
    logic [CMP_BITS-1:0]  w_height;
    logic [COL_BITS-1:0]  w_col;
    logic [ROW_BITS-1:0]  w_row;
    logic                 w_col_end;
    logic                 w_row_end;
    t_meta                w_meta;
    logic [LINE_BITS-1:0] w_rdata;
    logic [LINE_BITS-1:0] w_lines;
    logic [LINE_BITS-1:0] w_wdata;
    logic                 w_we;

    logic                 w_valid [WIN_AREA+1];
    t_win                 w_data  [WIN_AREA+1];
    t_meta                w_smeta [WIN_AREA+1];

    // advance the whole pipeline unless a result is stalled at the output
    assign w_adv       = !w_valid[WIN_AREA] || o_res.ready;
    assign i_pix.ready = w_adv;
    assign w_accept    = i_pix.valid && w_adv;

    always_comb begin
        w_width = CMP_BITS'(r_width);
        if (r_width == '0) begin
            w_width = CMP_BITS'(1);
        end else if (CMP_BITS'(r_width) > CMP_BITS'(MAX_WIDTH)) begin
            w_width = CMP_BITS'(MAX_WIDTH);
        end
        w_height = CMP_BITS'(r_height);
        if (r_height == '0) begin
            w_height = CMP_BITS'(1);
        end else if (CMP_BITS'(r_height) > CMP_BITS'(MAX_HEIGHT)) begin
            w_height = CMP_BITS'(MAX_HEIGHT);
        end
    end

    assign w_col     = i_pix.frame_start ? '0 : r_col;
    assign w_row     = i_pix.frame_start ? '0 : r_row;
    assign w_col_end = (CMP_BITS'(w_col) + CMP_BITS'(1)) >= w_width;
    assign w_row_end = (CMP_BITS'(w_row) + CMP_BITS'(1)) >= w_height;
    assign w_meta.full = (CMP_BITS'(w_col) >= CMP_BITS'(WINDOW - 1)) &&
                         (CMP_BITS'(w_row) >= CMP_BITS'(WINDOW - 1));
    assign w_meta.last = w_col_end && w_row_end;

    // line store: one word per column, holding the previous WINDOW-1 rows
    assign w_we    = r_s1_valid && w_adv;
    assign w_lines = r_fwd ? r_fwd_data : w_rdata;

    always_comb begin
        for (int r = 0; r < WINDOW - 2; r++) begin
            w_wdata[r*PIX_BITS +: PIX_BITS] = w_lines[(r+1)*PIX_BITS +: PIX_BITS];
        end
        w_wdata[(WINDOW-2)*PIX_BITS +: PIX_BITS] = r_s1_px;
    end

    imf_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1_col),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_col),
        .o_rdata (w_rdata)
    );

    // shift the window left and load the new column
    always_comb begin
        for (int r = 0; r < WINDOW; r++) begin
            for (int c = 0; c < WINDOW - 1; c++) begin
                n_win[r][c] = r_win[r][c+1];
            end
        end
        for (int r = 0; r < WINDOW - 1; r++) begin
            n_win[r][WINDOW-1] = w_lines[r*PIX_BITS +: PIX_BITS];
        end
        n_win[WINDOW-1][WINDOW-1] = r_s1_px;
        for (int r = 0; r < WINDOW; r++) begin
            for (int c = 0; c < WINDOW; c++) begin
                n_st0_data[r*WINDOW+c] = r_s1_meta.full ? n_win[r][c] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= RESET_WIDTH;
            r_height    <= RESET_HEIGHT;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_st0_valid <= 1'b0;
            for (int r = 0; r < WINDOW; r++) begin
                for (int c = 0; c < WINDOW; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (w_col_end) begin
                    r_col <= '0;
                    r_row <= w_row_end ? '0 : w_row + ROW_BITS'(1);
                end else begin
                    r_col <= w_col + COL_BITS'(1);
                    r_row <= w_row;
                end
            end
            if (w_adv) begin
                r_s1_valid  <= w_accept;
                r_st0_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_win <= n_win;
                end
            end
        end
        if (w_adv) begin
            r_s1_px    <= i_pix.pixel[PIX_BITS-1:0];
            r_s1_col   <= w_col;
            r_s1_meta  <= w_meta;
            // bypass a same-column write issued in this cycle
            r_fwd      <= r_s1_valid && (r_s1_col == w_col);
            r_fwd_data <= w_wdata;
            r_st0_data <= n_st0_data;
            r_st0_meta <= r_s1_meta;
        end
    end

    assign w_valid[0] = r_st0_valid;
    assign w_data[0]  = r_st0_data;
    assign w_smeta[0] = r_st0_meta;

    for (genvar k = 0; k < WIN_AREA; k++) begin : g_sort
        imf_sort_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_odd   ((k % 2) == 1),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .i_meta  (w_smeta[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1]),
            .o_meta  (w_smeta[k+1])
        );
    end

    assign o_res.valid        = w_valid[WIN_AREA];
    assign o_res.median_pixel = IO_PIX_BITS'(w_data[WIN_AREA][MED_IDX]);
    assign o_res.window_full  = w_smeta[WIN_AREA].full;
    assign o_res.frame_last   = w_smeta[WIN_AREA].last;

endmodule

`default_nettype wire

// ===== rtl/imf_checker.sv =====
// ----------------------------------------------------------------------------
// imf_checker: port-level assertions for the median filter
// Watches the input and output channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_median,
    input wire logic       i_full,
    input wire logic       i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_median) && $stable(i_full) && $stable(i_last))
        else $error("result changed while stalled");

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_full |-> i_median == 8'd0)
        else $error("border result carries a nonzero median");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input held off with no pending result");

    a_in_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_in_valid) && $past(!i_out_valid) && !i_out_valid |-> i_in_ready)
        else $error("input not ready with empty output");

endmodule

bind image_median_filter imf_checker u_imf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_median    (o_res.median_pixel),
    .i_full      (o_res.window_full),
    .i_last      (o_res.frame_last)
);

`default_nettype wire

// ===== bench/tb_image_median_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_median_filter: self-checking bench for the streaming median filter
// Streams raster pixels through the valid/ready channels under random idle
// and stall patterns and reprograms the frame size between phases. A local
// line-buffer and window model predicts each filtered pixel, which is
// compared field by field with the block's output in transaction order.
// ----------------------------------------------------------------------------
module tb_image_median_filter;
    import imf_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_IDLE      = 6;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = WIN_AREA + 8;
    localparam int RUN_LIMIT_NS  = 10_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS  = 44;
    localparam int LIMIT_PIXELS  = 12;

    typedef struct {
        t_pix median_pixel;
        logic window_full;
        logic frame_last;
    } t_filtered;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;

    imf_pix_if pix_if ();
    imf_res_if res_if ();

    image_median_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // filter model state
    logic [CFG_BITS-1:0] frame_width  = RESET_WIDTH;
    logic [CFG_BITS-1:0] frame_height = RESET_HEIGHT;
    t_pix                line_rows [WINDOW-1][MAX_WIDTH] = '{default: '0};
    t_pix                win_cells [WINDOW][WINDOW]      = '{default: '0};
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;
    t_filtered           filtered_q [$];

    bit calm        = 1'b0;
    bit hold_output = 1'b0;
    int errors       = 0;
    int pixels_sent  = 0;
    int results_seen = 0;
    int full_seen    = 0;
    int last_seen    = 0;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic int draw_idle();
        return calm ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic int unsigned clamp_dim(logic [CFG_BITS-1:0] v, int unsigned lim);
        if (v == '0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void predict_filter(t_pix px, logic fs);
        int unsigned w, h, c, r;
        t_pix        sorted [WIN_AREA];
        t_pix        v;
        int          n, k;
        t_filtered   res;
        w = clamp_dim(frame_width, MAX_WIDTH);
        h = clamp_dim(frame_height, MAX_HEIGHT);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        // shift window left, load the new column oldest row first
        for (int i = 0; i < WINDOW; i++)
            for (int j = 0; j < WINDOW - 1; j++)
                win_cells[i][j] = win_cells[i][j+1];
        for (int i = 0; i < WINDOW - 1; i++)
            win_cells[i][WINDOW-1] = line_rows[i][c];
        win_cells[WINDOW-1][WINDOW-1] = px;
        for (int i = 0; i < WINDOW - 2; i++)
            line_rows[i][c] = line_rows[i+1][c];
        line_rows[WINDOW-2][c] = px;
        n = 0;
        foreach (win_cells[i, j]) begin
            v = win_cells[i][j];
            k = n;
            while (k > 0 && sorted[k-1] > v) begin
                sorted[k] = sorted[k-1];
                k--;
            end
            sorted[k] = v;
            n++;
        end
        res.window_full  = (c >= WINDOW - 1) && (r >= WINDOW - 1);
        res.frame_last   = (c + 1 >= w) && (r + 1 >= h);
        res.median_pixel = res.window_full ? sorted[MED_IDX] : '0;
        filtered_q.push_back(res);
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    task automatic send_pixel(input t_pix px, input logic fs);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel       <= px;
        pix_if.frame_start <= fs;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        predict_filter(px, fs);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_frame_size(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        frame_width = w;
        i_cfg_idx  <= REG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        frame_height = h;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_geometry();
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(t_pix'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_small_frames();
        t_pix frame_px [12] = '{8'd255, 8'd255, 8'd255,
                                8'd0,   8'd255, 8'd0,
                                8'd255, 8'd0,   8'd255,
                                8'd0,   8'd0,   8'd0};
        set_frame_size(11'd3, 11'd4);
        foreach (frame_px[i])
            send_pixel(frame_px[i], i == 0);
        // run past the frame end without a new frame start
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd1, 1'b0);
    endtask

    task automatic test_degenerate_sizes();
        set_frame_size(11'd0, 11'd0);
        send_pixel(8'd77, 1'b1);
        send_pixel(8'd200, 1'b0);
    endtask

    task automatic test_resize_mid_frame();
        set_frame_size(11'd4, 11'd4);
        for (int i = 0; i < 6; i++)
            send_pixel(t_pix'($urandom_range(0, 255)), i == 0);
        // shrink while the column sits beyond the new width
        set_frame_size(11'd2, 11'd2);
        for (int i = 0; i < 3; i++)
            send_pixel(t_pix'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_size_limits();
        set_frame_size(11'd2047, 11'd3);
        for (int i = 0; i < LIMIT_PIXELS; i++)
            send_pixel(t_pix'($urandom_range(0, 255)), i == 0);
        set_frame_size(11'd1, 11'd2047);
        calm = 1'b1;
        for (int i = 0; i < LIMIT_PIXELS; i++)
            send_pixel(t_pix'($urandom_range(0, 255)), i == 0);
        calm = 1'b0;
    endtask

    task automatic test_random_frames();
        logic [CFG_BITS-1:0] w, h;
        logic                fs;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            w = ($urandom_range(0, 9) == 0) ? CFG_BITS'($urandom_range(0, 2))
                                            : CFG_BITS'($urandom_range(3, 12));
            if ($urandom_range(0, 9) == 0)
                h = $urandom_range(0, 1) ? 11'd2047 : CFG_BITS'($urandom_range(0, 2));
            else
                h = CFG_BITS'($urandom_range(3, 10));
            set_frame_size(w, h);
            calm = (phase == 2);
            if (phase == 4)
                hold_output = 1'b1;
            for (int i = 0; i < PHASE_PIXELS; i++) begin
                fs = (i == 0)
                     || (col_pos == 0 && row_pos == 0 && $urandom_range(0, 9) != 0)
                     || ($urandom_range(0, 39) == 0);
                send_pixel(t_pix'($urandom_range(0, 255)), fs);
            end
        end
        calm = 1'b0;
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
                stall = draw_idle();
            if (hold_output) begin
                stall = LONG_HOLD;
                hold_output = 1'b0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_filtered want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            results_seen++;
            if (filtered_q.size() == 0) begin
                errors++;
                $error("median_pixel: expected no transaction, got %0d",
                       res_if.median_pixel);
            end else begin
                want = filtered_q.pop_front();
                if (res_if.median_pixel !== want.median_pixel) begin
                    errors++;
                    $error("median_pixel: expected %0d, got %0d",
                           want.median_pixel, res_if.median_pixel);
                end
                if (res_if.window_full !== want.window_full) begin
                    errors++;
                    $error("window_full: expected %0b, got %0b",
                           want.window_full, res_if.window_full);
                end
                if (res_if.frame_last !== want.frame_last) begin
                    errors++;
                    $error("frame_last: expected %0b, got %0b",
                           want.frame_last, res_if.frame_last);
                end
                if (want.window_full) full_seen++;
                if (want.frame_last) last_seen++;
            end
        end
    end

    initial begin : run_limit
        #RUN_LIMIT_NS;
        $display("image_median_filter test failed");
        $finish;
    end

    initial begin : stimulus
        pix_if.valid       <= 1'b0;
        pix_if.pixel       <= '0;
        pix_if.frame_start <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= REG_WIDTH;
        i_cfg_data         <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_small_frames();
        test_degenerate_sizes();
        test_resize_mid_frame();
        test_size_limits();
        test_random_frames();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (filtered_q.size() != 0) begin
            errors++;
            $error("median_pixel: %0d results still outstanding", filtered_q.size());
        end

        $display("Streamed %0d pixels over default, tiny, clamped and random frame sizes",
                 pixels_sent);
        $display("Checked %0d results: %0d full windows, %0d frame ends, %0d mismatches",
                 results_seen, full_seen, last_seen, errors);
        if (errors == 0)
            $display("image_median_filter test passed");
        else
            $display("image_median_filter test failed");
        $finish;
    end

endmodule
